// File: rtl/homogeneous_vertex_transform_core_defines.svh
// Assertion macros for the RTL of the vertex transform core
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hvt assertion failed");

// implication with a fixed delay in cycles
`define HVT_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("hvt assertion failed");

`endif

// File: rtl/hvt_pkg.sv
// Package: types and constants of the vertex transform core
package hvt_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int NUM_REGS      = 8;
    localparam int CFG_W         = 64;
    localparam int IDX_W         = 3;
    localparam int DATA_W        = 32;
    localparam int NUM_LANES     = 4;
    localparam int LANE_LAT      = 3;

    localparam logic [1:0] OP_VEC4  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_DIR   = 2'd2;
    localparam logic [1:0] OP_PROJ  = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               saturated;
        logic               w_zero;
    } t_out;

    // per-transaction data riding alongside the divider pipeline
    typedef struct packed {
        logic                              valid;
        logic [1:0]                        op;
        logic [NUM_LANES-1:0][DATA_W-1:0]  r;
        logic                              sat;
    } t_side;

endpackage

// File: rtl/hvt_lane.sv
// One row lane: four products, exact sum, round to nearest, clip to 32 bits
module hvt_lane import hvt_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic [3:0][DATA_W-1:0] i_coef,
    input  logic [3:0][DATA_W-1:0] i_vec,
    output logic [DATA_W-1:0]      o_r,
    output logic                   o_sat
);

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;

    logic signed [63:0] r_prod [4];
    logic signed [64:0] r_s01, r_s23;
    logic signed [65:0] n_tot, n_sh;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_prod[c] <= $signed(i_coef[c]) * $signed(i_vec[c]);
        end
        r_s01 <= 65'(r_prod[0]) + 65'(r_prod[1]);
        r_s23 <= 65'(r_prod[2]) + 65'(r_prod[3]);
    end

    assign n_tot = 66'(r_s01) + 66'(r_s23) + HALF;
    assign n_sh  = n_tot >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (n_sh > MAXV) begin
            o_r   <= 32'h7fff_ffff;
            o_sat <= 1'b1;
        end else if (n_sh < MINV) begin
            o_r   <= 32'h8000_0000;
            o_sat <= 1'b1;
        end else begin
            o_r   <= n_sh[31:0];
            o_sat <= 1'b0;
        end
    end

endmodule

// File: rtl/hvt_div.sv
// Pipelined restoring divider: (n << FRAC_BITS) / w, truncated, clipped
module hvt_div import hvt_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_n,
    input  logic [DATA_W-1:0] i_w,
    output logic [DATA_W-1:0] o_q,
    output logic              o_sat
);

    localparam int QW = DATA_W + FRAC_BITS;

    logic [DATA_W-1:0] r_rem [QW+1];
    logic [QW-1:0]     r_dvd [QW+1];
    logic [DATA_W-1:0] r_dsr [QW+1];
    logic              r_neg [QW+1];
    logic [DATA_W-1:0] n_nmag, n_wmag;

    assign n_nmag = i_n[31] ? 32'(-i_n) : i_n;
    assign n_wmag = i_w[31] ? 32'(-i_w) : i_w;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_dvd[0] <= {n_nmag, {FRAC_BITS{1'b0}}};
        r_dsr[0] <= n_wmag;
        r_neg[0] <= i_n[31] ^ i_w[31];
    end

    // one quotient bit per stage; the dividend register fills with quotient bits
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DATA_W:0] w_cat, w_diff;
        assign w_cat  = {r_rem[k], r_dvd[k][QW-1]};
        assign w_diff = w_cat - {1'b0, r_dsr[k]};
        always_ff @(posedge i_clk) begin
            r_dsr[k+1] <= r_dsr[k];
            r_neg[k+1] <= r_neg[k];
            if (!w_diff[DATA_W]) begin
                r_rem[k+1] <= w_diff[DATA_W-1:0];
                r_dvd[k+1] <= {r_dvd[k][QW-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= w_cat[DATA_W-1:0];
                r_dvd[k+1] <= {r_dvd[k][QW-2:0], 1'b0};
            end
        end
    end

    logic [QW-1:0] w_q;
    logic          w_big, w_over;
    assign w_q    = r_dvd[QW];
    assign w_big  = |w_q[QW-1:31];
    assign w_over = |w_q[QW-1:32] | |w_q[30:0];

    always_ff @(posedge i_clk) begin
        if (!r_neg[QW]) begin
            o_q   <= w_big ? 32'h7fff_ffff : w_q[31:0];
            o_sat <= w_big;
        end else begin
            o_q   <= (w_big && w_over) ? 32'h8000_0000 : 32'(-w_q[31:0]);
            o_sat <= w_big && w_over;
        end
    end

    logic unused_rem;
    assign unused_rem = ^r_rem[QW];

endmodule

// File: rtl/hvt_merge.sv
// Merge stage: picks quotients or row sums, zero-w handling, flag combining
module hvt_merge import hvt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_side                  i_side,
    input  logic [2:0][DATA_W-1:0] i_q,
    input  logic [2:0]             i_qsat,
    output logic                   o_valid,
    output t_out                   o_res
);

    t_out n_res;
    logic w_proj, w_wz;

    assign w_proj = (i_side.op == OP_PROJ);
    assign w_wz   = w_proj && (i_side.r[3] == '0);

    always_comb begin
        logic [2:0][DATA_W-1:0] v;
        logic                   s;
        s = i_side.sat;
        for (int i = 0; i < 3; i++) begin
            if (!w_proj) begin
                v[i] = i_side.r[i];
            end else if (w_wz) begin
                if (i_side.r[i][31]) begin
                    v[i] = 32'h8000_0000;
                    s    = 1'b1;
                end else if (i_side.r[i] != '0) begin
                    v[i] = 32'h7fff_ffff;
                    s    = 1'b1;
                end else begin
                    v[i] = '0;
                end
            end else begin
                v[i] = i_q[i];
                s    = s | i_qsat[i];
            end
        end
        n_res.out_x     = v[0];
        n_res.out_y     = v[1];
        n_res.out_z     = v[2];
        n_res.out_w     = i_side.r[3];
        n_res.saturated = s;
        n_res.w_zero    = w_wz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_side.valid;
        end
        o_res <= n_res;
    end

endmodule

// File: rtl/homogeneous_vertex_transform_core.sv
// Homogeneous 4x4 transform core: one vertex transaction per cycle, never busy.
// Path of a transaction: the registered row lanes, the pipelined divider, the merge stage.
// Throughput: one transaction per clock; the divider pipeline sets the latency.
// Reset (sync, active low): matrix to identity, no transaction in flight.
// Results are shown for exactly one cycle on o_valid; the receiver cannot stall.
`include "homogeneous_vertex_transform_core_defines.svh"
module homogeneous_vertex_transform_core import hvt_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_item,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_valid,
    output t_out              o_result
);

    localparam int                DIV_LAT   = DATA_W + FRAC_BITS + 2;
    localparam int                TOTAL_LAT = LANE_LAT + DIV_LAT + 1;
    localparam logic [DATA_W-1:0] ONE       = DATA_W'(1) << FRAC_BITS;

    // fully pipelined: a new transaction can enter every cycle
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // matrix registers, column major, two rows per word
    logic [CFG_W-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= {32'd0, ONE};
            r_cfg[1] <= '0;
            r_cfg[2] <= {ONE, 32'd0};
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= {32'd0, ONE};
            r_cfg[6] <= '0;
            r_cfg[7] <= {ONE, 32'd0};
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // input vector; w depends on the mode
    logic [3:0][DATA_W-1:0] w_vec;
    always_comb begin
        w_vec[0] = i_item.in_x;
        w_vec[1] = i_item.in_y;
        w_vec[2] = i_item.in_z;
        case (i_item.op)
            OP_VEC4: w_vec[3] = i_item.in_w;
            OP_DIR:  w_vec[3] = '0;
            default: w_vec[3] = ONE;
        endcase
    end

    // four row lanes, one per output component
    logic [NUM_LANES-1:0][DATA_W-1:0] w_r;
    logic [NUM_LANES-1:0]             w_lsat;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        logic [3:0][DATA_W-1:0] w_coef;
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign w_coef[c] = (i % 2 == 1) ? r_cfg[c*2 + i/2][63:32]
                                            : r_cfg[c*2 + i/2][31:0];
        end
        hvt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_coef (w_coef),
            .i_vec  (w_vec),
            .o_r    (w_r[i]),
            .o_sat  (w_lsat[i])
        );
    end

    // transaction tags through the lanes
    logic       r_lv  [LANE_LAT];
    logic [1:0] r_lop [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_lv[k] <= 1'b0;
            end
        end else begin
            r_lv[0] <= accept;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_lv[k] <= r_lv[k-1];
            end
        end
        r_lop[0] <= i_item.op;
        for (int k = 1; k < LANE_LAT; k++) begin
            r_lop[k] <= r_lop[k-1];
        end
    end

    // perspective divide lanes for x, y, z against the computed w
    logic [2:0][DATA_W-1:0] w_q;
    logic [2:0]             w_qsat;

    for (genvar i = 0; i < 3; i++) begin : g_div
        hvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_n   (w_r[i]),
            .i_w   (w_r[3]),
            .o_q   (w_q[i]),
            .o_sat (w_qsat[i])
        );
    end

    // sums and flags wait alongside the divider
    t_side r_side [DIV_LAT];
    t_side n_side;

    always_comb begin
        n_side.valid = r_lv[LANE_LAT-1];
        n_side.op    = r_lop[LANE_LAT-1];
        n_side.r     = w_r;
        n_side.sat   = |w_lsat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else begin
            r_side[0].valid <= n_side.valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k].valid <= r_side[k-1].valid;
            end
        end
        r_side[0].op  <= n_side.op;
        r_side[0].r   <= n_side.r;
        r_side[0].sat <= n_side.sat;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_side[k].op  <= r_side[k-1].op;
            r_side[k].r   <= r_side[k-1].r;
            r_side[k].sat <= r_side[k-1].sat;
        end
    end

    hvt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side[DIV_LAT-1]),
        .i_q     (w_q),
        .i_qsat  (w_qsat),
        .o_valid (o_valid),
        .o_res   (o_result)
    );

    // any nonzero projected component on the result port
    logic w_any_nz;
    assign w_any_nz = (o_result.out_x != 0) || (o_result.out_y != 0) || (o_result.out_z != 0);

    // every accepted transaction yields a strobe a fixed number of cycles later
    `HVT_ASSERT_DLY(a_latency, i_clk, i_rst_n, accept, TOTAL_LAT, o_valid)
    // zero w with a nonzero numerator must flag saturation
    `HVT_ASSERT_NOW(a_wz_sat, i_clk, i_rst_n, o_valid && o_result.w_zero && w_any_nz, o_result.saturated)
    // w_zero only reports a zero computed w
    `HVT_ASSERT_NOW(a_wz_w, i_clk, i_rst_n, o_valid && o_result.w_zero, o_result.out_w == 0)

endmodule

// File: sim/hvt_checker.sv
// Checker: predicts vertex transform results and compares them with the core's output
`timescale 1ns / 1ps
module hvt_checker import hvt_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_in              i_item,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             o_valid,
    input  t_out             o_result,
    output int               o_fail_count,
    output int               o_pending
);

    logic [CFG_W-1:0] matrix_words [NUM_REGS];
    t_out             vertex_queue [$];

    assign o_pending = vertex_queue.size();

    function automatic logic signed [63:0] coeff(int row, int col);
        logic [63:0] word;
        word = matrix_words[col*2 + row/2];
        return (row % 2) ? 64'(signed'(word[63:32])) : 64'(signed'(word[31:0]));
    endfunction

    // exact sum of four products, round half up, clip to 32 bits
    function automatic logic signed [63:0] row_dot(int row, logic signed [63:0] v[4],
                                                   ref logic sat);
        logic signed [127:0] acc;
        logic signed [127:0] q;
        acc = 128'sd1 <<< (FRAC_BITS - 1);
        for (int c = 0; c < 4; c++)
            acc += 128'(coeff(row, c)) * 128'(v[c]);
        q = acc >>> FRAC_BITS;
        if (q > 128'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -128'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return 64'(q);
    endfunction

    function automatic logic signed [63:0] persp_div(logic signed [63:0] n,
                                                     logic signed [63:0] w, ref logic sat);
        logic signed [63:0] q;
        if (w == 0) begin
            if (n != 0)
                sat = 1'b1;
            return (n > 0) ? 64'sd2147483647 : (n < 0) ? -64'sd2147483648 : 64'sd0;
        end
        q = (n <<< FRAC_BITS) / w;
        if (q > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return q;
    endfunction

    function automatic t_out transform_vertex(t_in it);
        logic signed [63:0] v [4];
        logic signed [63:0] r [4];
        logic               sat;
        t_out               res;
        sat  = 1'b0;
        v[0] = 64'(it.in_x);
        v[1] = 64'(it.in_y);
        v[2] = 64'(it.in_z);
        case (it.op)
            OP_VEC4: v[3] = 64'(it.in_w);
            OP_DIR:  v[3] = 64'sd0;
            default: v[3] = 64'sd1 <<< FRAC_BITS;
        endcase
        for (int i = 0; i < 4; i++)
            r[i] = row_dot(i, v, sat);
        res.out_w  = r[3][31:0];
        res.w_zero = (it.op == OP_PROJ) && (r[3] == 0);
        if (it.op == OP_PROJ)
            for (int i = 0; i < 3; i++)
                r[i] = persp_div(r[i], r[3], sat);
        res.out_x     = r[0][31:0];
        res.out_y     = r[1][31:0];
        res.out_z     = r[2][31:0];
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            for (int i = 0; i < NUM_REGS; i++)
                matrix_words[i] <= (i == 0 || i == 5) ? 64'd1 << FRAC_BITS :
                                   (i == 2 || i == 7) ? 64'd1 << (FRAC_BITS + 32) : 64'd0;
            vertex_queue.delete();
        end else begin
            if (o_valid) begin
                if (vertex_queue.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    want = vertex_queue.pop_front();
                    if (o_result.out_x !== want.out_x)
                        report_mismatch("out_x", o_result.out_x, want.out_x);
                    if (o_result.out_y !== want.out_y)
                        report_mismatch("out_y", o_result.out_y, want.out_y);
                    if (o_result.out_z !== want.out_z)
                        report_mismatch("out_z", o_result.out_z, want.out_z);
                    if (o_result.out_w !== want.out_w)
                        report_mismatch("out_w", o_result.out_w, want.out_w);
                    if (o_result.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(o_result.saturated),
                                        32'(want.saturated));
                    if (o_result.w_zero !== want.w_zero)
                        report_mismatch("w_zero", 32'(o_result.w_zero), 32'(want.w_zero));
                end
            end
            if (start && !busy)
                vertex_queue.push_back(transform_vertex(i_item));
            if (i_cfg_we)
                matrix_words[i_cfg_idx] <= i_cfg_data;
        end
    end

endmodule

// File: sim/tb_homogeneous_vertex_transform_core.sv
// Testbench top: drives vertex and matrix transactions and reports the verdict
`timescale 1ns / 1ps
module tb_homogeneous_vertex_transform_core;
    import hvt_pkg::*;

    localparam int LATENCY    = DEF_FRAC_BITS + 38;
    localparam int N_RANDOM   = 1050;
    localparam int CYCLE_CAP  = 200000;
    localparam int IDX_COL0_01 = 0;
    localparam int IDX_COL3_23 = 7;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in              i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_valid;
    t_out             o_result;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;

    always #1 i_clk = ~i_clk;

    homogeneous_vertex_transform_core uut (
        .i_clk, .i_rst_n, .start, .busy, .i_item,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_valid, .o_result
    );

    hvt_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_item,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_valid, .o_result,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: a hung pipeline must not run forever
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // interesting 32-bit values: extremes, zero, +-1.0, small random and plain random
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5, 6: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
            default: return $urandom;
        endcase
    endfunction

    // one start transaction; start stays high across back-to-back items
    task automatic send_vertex(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [31:0] w);
        start       <= 1'b1;
        i_item.op   <= op;
        i_item.in_x <= x;
        i_item.in_y <= y;
        i_item.in_z <= z;
        i_item.in_w <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 8))
            @(posedge i_clk);
    endtask

    // wait out the pipeline so matrix writes never land mid-flight
    task automatic drain();
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4)
            @(posedge i_clk);
    endtask

    // the write enable stays high until the following drain
    task automatic write_word(int idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= IDX_W'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // load all eight words; style picks small, random, extreme or all-zero
    task automatic load_matrix(int style);
        logic [31:0] lo, hi;
        for (int i = IDX_COL0_01; i <= IDX_COL3_23; i++) begin
            case (style)
                0: begin
                    lo = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
                    hi = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
                end
                1: begin
                    lo = pick_coord();
                    hi = pick_coord();
                end
                2: begin
                    lo = (i % 2) ? 32'h80000000 : 32'h7fffffff;
                    hi = (i % 2) ? 32'h7fffffff : 32'h80000000;
                end
                default: begin
                    lo = 32'h0;
                    hi = 32'h0;
                end
            endcase
            write_word(i, {hi, lo});
        end
    endtask

    initial begin
        logic [1:0] op;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity matrix, every mode, field extremes
        send_vertex(OP_VEC4,  32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000);
        send_vertex(OP_POINT, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0);
        send_vertex(OP_DIR,   32'h00010000, 32'hffff0000, 32'h7fffffff, 32'h7fffffff);
        send_vertex(OP_PROJ,  32'h00020000, 32'hfffe0000, 32'h0, 32'h0);
        send_vertex(OP_VEC4,  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_vertex(OP_VEC4,  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_vertex(OP_VEC4,  32'h1, 32'hffffffff, 32'h0, 32'h0);
        drain();
        // every coefficient zero: projection meets w of zero
        load_matrix(3);
        drain();
        send_vertex(OP_PROJ, 32'h00010000, 32'h1, 32'h0, 32'h0);
        send_vertex(OP_VEC4, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
        drain();
        // extreme coefficients: row sums clip
        load_matrix(2);
        drain();
        send_vertex(OP_VEC4, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_vertex(OP_PROJ, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
        send_vertex(OP_DIR,  32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
        send_vertex(OP_POINT, 32'h00010000, 32'h0, 32'hffff0000, 32'h0);
        // small random coefficients with a tiny w weight in row 3, then projections
        drain();
        load_matrix(0);
        write_word(7, {32'h00000001, 32'h00000000});
        drain();
        send_vertex(OP_PROJ, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'h0);
        send_vertex(OP_PROJ, 32'h00100000, 32'hfff00000, 32'h0, 32'h0);
        drain();

        // random phases, each under a fresh matrix
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 0) begin
                drain();
                load_matrix((n / 150) % 3);
                drain();
            end
            op = 2'($urandom_range(0, 3));
            send_vertex(op, pick_coord(), pick_coord(), pick_coord(), pick_coord());
            // last stretch runs back-to-back
            if (n < N_RANDOM - 100 && $urandom_range(0, 3) == 0)
                idle_burst();
        end
        drain();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
